### design/kvl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_pkg
// shared types, sizes and codes for the keyed version ledger
// ----------------------------------------------------------------------------
package kvl_pkg;

  localparam int TABLE_ROWS        = 64;
  localparam int PEER_KEY_BYTES    = 32;
  localparam int SUBJECT_KEY_BYTES = 32;

  localparam int KEY_BITS  = 256;
  localparam int KIND_W    = 32;
  localparam int VER_W     = 64;
  localparam int LIMIT_W   = 7;
  localparam int ROW_AW    = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CNT_W     = $clog2(TABLE_ROWS + 1);

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_STALE     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KEY_BITS-1:0] subject;
    logic [KEY_BITS-1:0] peer;
  } kvl_key_t;

  typedef struct packed {
    logic [VER_W-1:0] version;
    kvl_key_t         key;
  } kvl_row_t;

  // keeps only the bytes that lie within a key of nbytes bytes
  function automatic logic [KEY_BITS-1:0] key_mask(input int nbytes);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BITS / 8; i++) begin
      if (i < nbytes) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [KEY_BITS-1:0] PEER_MASK    = key_mask(PEER_KEY_BYTES);
  localparam logic [KEY_BITS-1:0] SUBJECT_MASK = key_mask(SUBJECT_KEY_BYTES);

endpackage
`default_nettype wire

### design/kvl_row_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_row_store
// row memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module kvl_row_store
  import kvl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ROW_AW-1:0] wr_addr,
  input  wire kvl_row_t          wr_data,
  input  wire logic              rd_en,
  input  wire logic [ROW_AW-1:0] rd_addr,
  output kvl_row_t               rd_data
);

  kvl_row_t mem [TABLE_ROWS];
  kvl_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/kvl_key_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_key_match
// shared key comparator: stored row key against the probe key
// ----------------------------------------------------------------------------
module kvl_key_match
  import kvl_pkg::*;
(
  input  wire kvl_key_t row_key,
  input  wire kvl_key_t probe_key,
  output logic          hit
);

  logic kind_eq;
  logic peer_eq;
  logic subj_eq;

  always_comb begin
    kind_eq = (row_key.kind == probe_key.kind);
    peer_eq = (row_key.peer == probe_key.peer);
    subj_eq = (row_key.subject == probe_key.subject);
    hit     = kind_eq && peer_eq && subj_eq;
  end

endmodule
`default_nettype wire

### design/keyed_version_ledger_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_version_ledger_unit
// ledger of confirmed versions keyed by peer, subject and kind
// ----------------------------------------------------------------------------
// steps: after the item is taken, the scan reads one used row per cycle and
//   compares each read row against the probe; a hit at row i ends the scan
//   there, else a closing step ends the scan after the compare of the last
//   read; the decide/update step then registers the result
// a new item is taken only once the previous result has been registered;
//   a result not yet taken keeps the decide step waiting
// reset: rows_used cleared, row_limit set to 64, row memory left as is
//   (rows at or above rows_used are never read, so no clearing pass)
module keyed_version_ledger_unit
  import kvl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration: row_limit
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data,
  // input item stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // peer_word_0..3 [255:0], subject_word_0..3 [511:256], kind [543:512],
  // version_or_current [607:544]
  input  wire logic [607:0]       in_tdata,
  // func (0 confirm, 1 query)
  input  wire logic               in_tuser,
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // status [1:0], held_version [65:2], behind [66], row_count [73:67],
  // zero fill [79:74]
  output logic [79:0]             out_tdata
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [LIMIT_W-1:0] row_limit_r;
  logic [CNT_W-1:0]   rows_used_r, rows_used_nxt;

  // latched item
  kvl_key_t           probe_r, probe_nxt;
  logic [VER_W-1:0]   ver_r, ver_nxt;
  logic               func_r, func_nxt;

  // scan progress
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [ROW_AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               found_r, found_nxt;
  logic [ROW_AW-1:0]  at_r, at_nxt;
  logic [VER_W-1:0]   held_r, held_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [79:0]        out_data_r, out_data_nxt;

  // memory and comparator hookup
  logic               mem_rd_en;
  logic [ROW_AW-1:0]  mem_rd_addr;
  kvl_row_t           mem_rd_data;
  logic               mem_wr_en;
  logic [ROW_AW-1:0]  mem_wr_addr;
  kvl_row_t           mem_wr_data;
  logic               key_hit;

  // decide-step working values
  logic               in_accept;
  logic               limit_full;
  logic [1:0]         res_status;
  logic [VER_W-1:0]   res_held;
  logic               res_behind;
  logic [CNT_W-1:0]   limit_cnt;

  kvl_row_store u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  kvl_key_match u_match (
    .row_key   (mem_rd_data.key),
    .probe_key (probe_r),
    .hit       (key_hit)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // limit in force is min(row_limit, TABLE_ROWS)
  always_comb begin
    if (CNT_W'(row_limit_r) < CNT_W'(TABLE_ROWS) && int'(row_limit_r) < TABLE_ROWS) begin
      limit_cnt = CNT_W'(row_limit_r);
    end else begin
      limit_cnt = CNT_W'(TABLE_ROWS);
    end
    limit_full = (rows_used_r >= limit_cnt);
  end

  always_comb begin
    state_nxt     = state_r;
    rows_used_nxt = rows_used_r;
    probe_nxt     = probe_r;
    ver_nxt       = ver_r;
    func_nxt      = func_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    at_nxt        = at_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = scan_idx_r[ROW_AW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = at_r;
    mem_wr_data   = '{version: ver_r, key: probe_r};
    res_status    = ST_OK;
    res_held      = held_r;
    res_behind    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          probe_nxt.peer    = in_tdata[255:0] & PEER_MASK;
          probe_nxt.subject = in_tdata[511:256] & SUBJECT_MASK;
          probe_nxt.kind    = in_tdata[543:512];
          ver_nxt           = in_tdata[607:544];
          func_nxt          = in_tuser;
          scan_idx_nxt      = '0;
          found_nxt         = 1'b0;
          held_nxt          = '0;
          state_nxt         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld_r && key_hit) begin
          // row that came out of the memory matches
          found_nxt = 1'b1;
          at_nxt    = cmp_idx_r;
          held_nxt  = mem_rd_data.version;
          state_nxt = S_DONE;
        end else if (scan_idx_r < rows_used_r) begin
          mem_rd_en    = 1'b1;
          cmp_idx_nxt  = scan_idx_r[ROW_AW-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          rd_vld_nxt   = 1'b1;
        end else if (!rd_vld_r) begin
          // every used row checked, key absent
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          if (func_r) begin
            res_behind = (held_r < ver_r);
          end else if (ver_r == '0) begin
            res_status = ST_MALFORMED;
          end else if (found_r) begin
            if (ver_r <= held_r) begin
              res_status = ST_STALE;
            end else begin
              mem_wr_en = 1'b1;
              res_held  = ver_r;
            end
          end else if (limit_full) begin
            res_status = ST_FULL;
            res_held   = '0;
          end else begin
            // append at the first free row
            mem_wr_en     = 1'b1;
            mem_wr_addr   = rows_used_r[ROW_AW-1:0];
            rows_used_nxt = rows_used_r + CNT_W'(1);
            res_held      = ver_r;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, 7'(rows_used_nxt), res_behind, res_held, res_status};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_used_r <= '0;
      row_limit_r <= LIMIT_W'(64);
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_used_r <= rows_used_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (cfg_wr_en) row_limit_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    probe_r    <= probe_nxt;
    ver_r      <= ver_nxt;
    func_r     <= func_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    at_r       <= at_nxt;
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // the row count never passes the table size
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_used_r <= CNT_W'(TABLE_ROWS))
    else $error("row count beyond table size");

  // a result is only loaded from the decide step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside decide step");

  // the scan never reads at or beyond the used rows
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> (scan_idx_r < rows_used_r))
    else $error("scan read beyond used rows");

  // rows are only added one at a time by a confirm
  a_rows_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rows_used_r != $past(rows_used_r)) |->
      (rows_used_r == $past(rows_used_r) + CNT_W'(1)) && !$past(func_r))
    else $error("row count moved unexpectedly");
`endif

endmodule
`default_nettype wire
